@@ hw/rtl/mavg_pkg.sv @@
// Shared constants and types for the moving average filter.
package mavg_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int SAMPLE_W       = 16;
    localparam int AVG_W          = 24;
    localparam int FRAC_W         = 8;
    localparam int WLEN_W         = 5;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    localparam logic [WLEN_W-1:0]   WLEN_RESET        = 5'd3;
    localparam logic [APB_AW-3:0]   REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

endpackage

@@ hw/rtl/mavg_ring.sv @@
// Sample history ring storage, one write port and one registered read port.
module mavg_ring
    import mavg_pkg::*;
#(
    parameter int DEPTH = WINDOW_MAX_DEF,
    parameter int IDX_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [IDX_W-1:0]           i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]           i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mavg_div.sv @@
// Iterative restoring divider with floored signed quotient.
module mavg_div
    import mavg_pkg::*;
#(
    parameter int NUM_W = 29,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W:0]   o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } t_dv_state;

    t_dv_state        r_state;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_done;
    logic [NUM_W:0]   r_quot;

    logic [DEN_W:0]   n_shift;
    logic [DEN_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_q[NUM_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                DV_IDLE: begin
                    if (i_req.start) begin
                        r_q     <= i_num;
                        r_rem   <= '0;
                        r_den   <= i_den;
                        r_neg   <= i_req.neg;
                        r_cnt   <= CNT_W'(NUM_W);
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    r_q   <= {r_q[NUM_W-2:0], ~n_diff[DEN_W]};
                    r_rem <= n_diff[DEN_W] ? n_shift[DEN_W-1:0] : n_diff[DEN_W-1:0];
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    // floor toward minus infinity for negative dividends
                    if (!r_neg) begin
                        r_quot <= {1'b0, r_q};
                    end else if (r_rem != '0) begin
                        r_quot <= ~{1'b0, r_q};
                    end else begin
                        r_quot <= (NUM_W+1)'(0) - {1'b0, r_q};
                    end
                    r_done  <= 1'b1;
                    r_state <= DV_IDLE;
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/moving_average_filter.sv @@
// Top level of the moving average filter: ring control, running sum, APB register.
// The divider numerator is NUM_W = 16 + clog2(WINDOW_MAX+1) + 8 bits wide (29 at WINDOW_MAX = 16);
// the divider does one quotient bit per cycle.
// o_stall is high while a sample is in work; no new sample is taken until its result is in the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low): window length 3, empty history, zero sum, no result pending.
module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [AVG_W-1:0]    o_average,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = SAMPLE_W + FILL_W;
    localparam int NUM_W  = SUM_W + FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                     r_state;
    logic [WLEN_W-1:0]          r_wlen;
    logic [FILL_W-1:0]          r_fill;
    logic [IDX_W-1:0]           r_oldest;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [AVG_W-1:0]    r_average;
    logic                       r_out_valid;

    logic [FILL_W-1:0]          n_weff;
    logic                       n_full;
    logic                       n_cfg_wr;
    logic signed [SUM_W-1:0]    n_sum;
    logic [IDX_W-1:0]           n_oldest;
    logic [SUM_W-1:0]           n_mag;
    logic signed [SUM_W-1:0]    n_samp_ext;
    logic signed [SUM_W-1:0]    n_old_ext;

    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic signed [SAMPLE_W-1:0] w_rdata;
    t_div_req                   w_div_req;
    logic                       w_div_done;
    logic [NUM_W:0]             w_div_quot;

    always_comb begin
        if (r_wlen == '0) begin
            n_weff = FILL_W'(1);
        end else if (int'(r_wlen) > WINDOW_MAX) begin
            n_weff = FILL_W'(WINDOW_MAX);
        end else begin
            n_weff = FILL_W'(r_wlen);
        end
        n_full     = (r_fill == n_weff);
        n_samp_ext = {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
        n_old_ext  = {{(SUM_W-SAMPLE_W){w_rdata[SAMPLE_W-1]}}, w_rdata};
        n_sum      = n_full ? (r_sum - n_old_ext + n_samp_ext) : (r_sum + n_samp_ext);
        n_oldest   = (FILL_W'(r_oldest) + FILL_W'(1) == n_weff) ? '0 : r_oldest + IDX_W'(1);
        n_mag      = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        n_cfg_wr   = psel && penable && pwrite && pready
                     && (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH);
    end

    assign w_we          = (r_state == ST_READ);
    assign w_waddr       = n_full ? r_oldest : r_fill[IDX_W-1:0];
    assign w_div_req.start = (r_state == ST_START);
    assign w_div_req.neg   = r_sum[SUM_W-1];

    mavg_ring #(
        .DEPTH (WINDOW_MAX),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_raddr (r_oldest),
        .o_rdata (w_rdata)
    );

    mavg_div #(
        .NUM_W (NUM_W),
        .DEN_W (FILL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   ({n_mag, FRAC_W'(0)}),
        .i_den   (r_fill),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wlen      <= WLEN_RESET;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_sum <= n_sum;
                    if (n_full) begin
                        r_oldest <= n_oldest;
                    end else begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_average   <= w_div_quot[AVG_W-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (n_cfg_wr) begin
                // window change drops the history
                r_wlen   <= pwdata[WLEN_W-1:0];
                r_fill   <= '0;
                r_oldest <= '0;
                r_sum    <= '0;
            end
        end
    end

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_average = r_average;
    assign prdata    = (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH) ? APB_DW'(r_wlen) : '0;
    assign pready    = 1'b1;

endmodule

@@ hw/rtl/mavg_chk.sv @@
// Port-level checker for the moving average filter, bound to the top level.
module mavg_chk
    import mavg_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [AVG_W-1:0]    o_average
);

    // a taken sample blocks further input while in work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transaction");

    // a new result only comes out of a sample in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a sample in work");

    // nothing pending: a taken result leaves the output empty
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_stall) |=> !o_valid)
        else $error("result repeated or invented");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_average)))
        else $error("stalled result changed");

endmodule

bind moving_average_filter mavg_chk u_mavg_chk (.*);
